// ----- rtl/srsd_pkg.sv -----
// Shared types and constants for the run-length sprite slice decoder.
package srsd_pkg;

    localparam int SUM_W = 36;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_RUN    = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SLICE_WORD,
        PH_OFFSETS,
        PH_RAW,
        PH_BLOCK,
        PH_REPEAT_PIX,
        PH_LITERAL,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [15:0] right_x;
        logic [15:0] left_x;
        logic [15:0] left_y;
        logic [15:0] right_y;
    } t_extents;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] pixel_index;
        logic [7:0]  pixel_value;
        logic [6:0]  run_count;
        logic [16:0] frame_width;
        logic [16:0] frame_height;
        logic        out_of_range;
    } t_result;

endpackage

// ----- rtl/srsd_geometry.sv -----
// Frame geometry pipeline: width, pixel limit and row base derived from the extents.
module srsd_geometry
    import srsd_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int WPW        = $clog2(MAX_PIXELS + 1)
) (
    input  logic             i_clk,
    input  t_extents         i_extents,
    output logic [16:0]      o_width,
    output logic [WPW-1:0]   o_limit,
    output logic [SUM_W-1:0] o_base
);

    localparam logic [33:0]    MaxArea  = 34'(MAX_PIXELS);
    localparam logic [WPW-1:0] MaxLimit = WPW'(MAX_PIXELS);

    logic [16:0]      r_width;
    logic [16:0]      r_height;
    logic [15:0]      r_left_x;
    logic [15:0]      r_left_y;
    logic [33:0]      r_area;
    logic [32:0]      r_lyw;
    logic [15:0]      r_left_x2;
    logic [WPW-1:0]   r_limit;
    logic [SUM_W-1:0] r_base;

    always_ff @(posedge i_clk) begin
        r_width   <= 17'(i_extents.left_x) + 17'(i_extents.right_x) + 17'd1;
        r_height  <= 17'(i_extents.left_y) + 17'(i_extents.right_y) + 17'd1;
        r_left_x  <= i_extents.left_x;
        r_left_y  <= i_extents.left_y;

        r_area    <= 34'(r_width) * 34'(r_height);
        r_lyw     <= 33'(r_left_y) * 33'(r_width);
        r_left_x2 <= r_left_x;

        r_limit   <= (r_area < MaxArea) ? r_area[WPW-1:0] : MaxLimit;
        r_base    <= SUM_W'(r_lyw) + SUM_W'(r_left_x2);
    end

    assign o_width = r_width;
    assign o_limit = r_limit;
    assign o_base  = r_base;

endmodule

// ----- rtl/srsd_parser.sv -----
// Byte parser: header, slice and block state machine with run generation.
module srsd_parser
    import srsd_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576,
    parameter int WPW        = $clog2(MAX_PIXELS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_data_byte,
    input  logic             i_frame_start,
    input  logic [16:0]      i_width,
    input  logic [WPW-1:0]   i_limit,
    input  logic [SUM_W-1:0] i_base,
    output t_extents         o_extents,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_phase           r_phase, n_phase;
    logic [2:0]       r_pos, n_pos;
    logic [7:0]       r_held, n_held;
    t_extents         r_ext, n_ext;
    logic [15:0]      r_off_x, n_off_x;
    logic [14:0]      r_rem, n_rem;
    logic             r_comp, n_comp;
    logic [6:0]       r_blk, n_blk;
    logic             r_rep, n_rep;
    logic [WPW-1:0]   r_wp, n_wp;
    logic signed [SUM_W-1:0] r_part, n_part;

    t_phase           c_phase;
    logic [2:0]       c_pos;
    logic [15:0]      word;
    logic [24:0]      prod_lo;
    logic signed [25:0] prod_hi;
    logic signed [SUM_W-1:0] start_sum;
    logic             do_emit;
    logic [6:0]       e_count;
    logic [WPW:0]     run_end;
    logic             run_oor;
    logic [WPW+19:0]  idx_ext;
    logic [SUM_W-1:0] limit_ext;

    assign word      = {i_data_byte, r_held};
    assign prod_lo   = 25'(i_data_byte) * 25'(i_width);
    assign prod_hi   = 26'($signed(i_data_byte)) * 26'($signed({1'b0, i_width}));
    assign start_sum = r_part + $signed({{(SUM_W-34){prod_hi[25]}}, prod_hi, 8'b0});
    assign run_end   = {1'b0, r_wp} + (WPW+1)'(e_count);
    assign run_oor   = run_end > {1'b0, i_limit};
    assign idx_ext   = {20'b0, r_wp};
    assign limit_ext = SUM_W'(i_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_held  <= '0;
            r_ext   <= '0;
            r_off_x <= '0;
            r_rem   <= '0;
            r_comp  <= 1'b0;
            r_blk   <= '0;
            r_rep   <= 1'b0;
            r_wp    <= '0;
            r_part  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_held  <= n_held;
            r_ext   <= n_ext;
            r_off_x <= n_off_x;
            r_rem   <= n_rem;
            r_comp  <= n_comp;
            r_blk   <= n_blk;
            r_rep   <= n_rep;
            r_wp    <= n_wp;
            r_part  <= n_part;
        end
    end

    always_comb begin
        c_phase     = i_frame_start ? PH_HEADER : r_phase;
        c_pos       = i_frame_start ? 3'd0 : r_pos;
        n_phase     = c_phase;
        n_pos       = c_pos;
        n_held      = r_held;
        n_ext       = i_frame_start ? '0 : r_ext;
        n_off_x     = r_off_x;
        n_rem       = r_rem;
        n_comp      = r_comp;
        n_blk       = r_blk;
        n_rep       = r_rep;
        n_wp        = r_wp;
        n_part      = r_part;
        do_emit     = 1'b0;
        e_count     = 7'd1;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (c_phase)
            PH_HEADER: begin
                if (!c_pos[0]) begin
                    n_held = i_data_byte;
                end else begin
                    unique case (c_pos[2:1])
                        2'd0:    n_ext.right_x = word;
                        2'd1:    n_ext.left_x  = word;
                        2'd2:    n_ext.left_y  = word;
                        default: n_ext.right_y = word;
                    endcase
                end
                if (c_pos == 3'd7) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_HEADER;
                    o_res.frame_width  = 17'(n_ext.left_x) + 17'(n_ext.right_x) + 17'd1;
                    o_res.frame_height = 17'(n_ext.left_y) + 17'(n_ext.right_y) + 17'd1;
                    n_pos              = 3'd0;
                    n_wp               = '0;
                    n_phase            = PH_SLICE_WORD;
                end else begin
                    n_pos = c_pos + 3'd1;
                end
            end
            PH_SLICE_WORD: begin
                if (c_pos == 3'd0) begin
                    n_held = i_data_byte;
                    n_pos  = 3'd1;
                end else begin
                    n_pos = 3'd0;
                    if (word == 16'd0) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_END;
                        n_phase     = PH_DONE;
                    end else begin
                        n_comp  = word[0];
                        n_rem   = word[15:1];
                        n_phase = PH_OFFSETS;
                    end
                end
            end
            PH_OFFSETS: begin
                priority if (c_pos == 3'd0) begin
                    n_held = i_data_byte;
                    n_pos  = 3'd1;
                end else if (c_pos == 3'd1) begin
                    n_off_x = word;
                    n_pos   = 3'd2;
                end else if (c_pos == 3'd2) begin
                    n_held = i_data_byte;
                    n_pos  = 3'd3;
                    n_part = $signed(i_base)
                           + $signed({{(SUM_W-16){r_off_x[15]}}, r_off_x})
                           + $signed(SUM_W'(prod_lo));
                end else begin
                    n_pos = 3'd0;
                    if (start_sum[SUM_W-1]) begin
                        n_wp = '0;
                    end else if (start_sum > $signed(limit_ext)) begin
                        n_wp = i_limit;
                    end else begin
                        n_wp = start_sum[WPW-1:0];
                    end
                    if (r_rem == 15'd0) begin
                        n_phase = PH_SLICE_WORD;
                    end else begin
                        n_phase = r_comp ? PH_BLOCK : PH_RAW;
                    end
                end
            end
            PH_RAW: begin
                do_emit = 1'b1;
                n_rem   = (r_rem != 15'd0) ? r_rem - 15'd1 : 15'd0;
                if (n_rem == 15'd0) begin
                    n_phase = PH_SLICE_WORD;
                end
            end
            PH_BLOCK: begin
                n_rep = i_data_byte[0];
                n_blk = i_data_byte[7:1];
                n_rem = (r_rem > 15'(i_data_byte[7:1])) ? r_rem - 15'(i_data_byte[7:1])
                                                         : 15'd0;
                priority if (i_data_byte[0]) begin
                    n_phase = PH_REPEAT_PIX;
                end else if (i_data_byte[7:1] == 7'd0) begin
                    n_phase = (n_rem != 15'd0) ? PH_BLOCK : PH_SLICE_WORD;
                end else begin
                    n_phase = PH_LITERAL;
                end
            end
            PH_REPEAT_PIX: begin
                do_emit = 1'b1;
                e_count = r_blk;
                n_blk   = 7'd0;
                n_phase = (r_rem != 15'd0) ? PH_BLOCK : PH_SLICE_WORD;
            end
            PH_LITERAL: begin
                do_emit = 1'b1;
                n_blk   = (r_blk != 7'd0) ? r_blk - 7'd1 : 7'd0;
                if (n_blk == 7'd0) begin
                    n_phase = (r_rem != 15'd0) ? PH_BLOCK : PH_SLICE_WORD;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
        endcase

        if (do_emit && (e_count != 7'd0)) begin
            o_res_valid        = 1'b1;
            o_res.kind         = KIND_RUN;
            o_res.pixel_index  = idx_ext[19:0];
            o_res.pixel_value  = i_data_byte;
            o_res.run_count    = e_count;
            o_res.out_of_range = run_oor;
            n_wp               = run_oor ? i_limit : run_end[WPW-1:0];
        end
    end

    assign o_extents = r_ext;

endmodule

// ----- rtl/sprite_rle_slice_decoder.sv -----
// Top level of the run-length sprite slice decoder.
// An accepted input byte is held in the input register; the parser's result for it is
// captured in the result register when the result register is empty or not stalled.
// Throughput: one byte per cycle; stalls only with both registers full and i_stall high.
// Reset: synchronous, active low; the parser returns to awaiting a frame header
// and both registers are emptied.
module sprite_rle_slice_decoder
    import srsd_pkg::*;
#(
    parameter int MAX_PIXELS = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [19:0] o_pixel_index,
    output logic [7:0]  o_pixel_value,
    output logic [6:0]  o_run_count,
    output logic [16:0] o_frame_width,
    output logic [16:0] o_frame_height,
    output logic        o_out_of_range
);

    localparam int WPW = $clog2(MAX_PIXELS + 1);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;
    logic             r_out_valid;
    t_result          r_out;

    logic             adv;
    logic             res_valid;
    t_result          res;
    t_extents         extents;
    logic [16:0]      width;
    logic [WPW-1:0]   limit;
    logic [SUM_W-1:0] base;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    srsd_geometry #(
        .MAX_PIXELS (MAX_PIXELS),
        .WPW        (WPW)
    ) u_geometry (
        .i_clk     (i_clk),
        .i_extents (extents),
        .o_width   (width),
        .o_limit   (limit),
        .o_base    (base)
    );

    srsd_parser #(
        .MAX_PIXELS (MAX_PIXELS),
        .WPW        (WPW)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_data_byte   (r_in_byte),
        .i_frame_start (r_in_start),
        .i_width       (width),
        .i_limit       (limit),
        .i_base        (base),
        .o_extents     (extents),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_pixel_index  = r_out.pixel_index;
    assign o_pixel_value  = r_out.pixel_value;
    assign o_run_count    = r_out.run_count;
    assign o_frame_width  = r_out.frame_width;
    assign o_frame_height = r_out.frame_height;
    assign o_out_of_range = r_out.out_of_range;

endmodule

// ----- rtl/srsd_checker.sv -----
// Port-level checks for the sprite slice decoder and their binding to the top level.
module srsd_checker
    import srsd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_frame_start,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [19:0] o_pixel_index,
    input logic [7:0]  o_pixel_value,
    input logic [6:0]  o_run_count,
    input logic [16:0] o_frame_width,
    input logic [16:0] o_frame_height,
    input logic        o_out_of_range
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_pixel_index)
            && $stable(o_run_count) && $stable(o_out_of_range))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_RUN) |-> (o_run_count != 7'd0)
            && (o_frame_width == 17'd0) && (o_frame_height == 17'd0))
        else $error("run word with zero count or geometry fields");

    a_header_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_HEADER) |-> (o_pixel_index == 20'd0)
            && (o_run_count == 7'd0) && !o_out_of_range && (o_frame_width != 17'd0))
        else $error("header word carries pixel fields");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_END) |-> (o_pixel_index == 20'd0)
            && (o_pixel_value == 8'd0) && (o_run_count == 7'd0)
            && (o_frame_width == 17'd0) && (o_frame_height == 17'd0) && !o_out_of_range)
        else $error("frame end word carries nonzero fields");

endmodule

bind sprite_rle_slice_decoder srsd_checker u_srsd_checker (.*);
